>>> src/msq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msq_pkg
// Shared types, constants and edge tables of the marching squares segment
// generator.
// ----------------------------------------------------------------------------
package msq_pkg;

	// fixed point format of all coordinates
	localparam int FRAC_BITS = 8;
	localparam int FW        = FRAC_BITS + 1;             // fraction incl. 1.0
	localparam int PIX_W     = 8;
	localparam int ROW_W     = 10;
	localparam int HGT_W     = 11;
	localparam int MAX_HEIGHT = 1024;
	localparam int COORD_W   = 18;
	localparam int NORM_W    = 11;
	localparam int DIV_NW    = PIX_W + FRAC_BITS + 1;     // divider dividend
	localparam int DIV_DW    = PIX_W + 1;                 // divider divisor
	localparam int DIV_CW    = $clog2(FRAC_BITS);

	localparam logic [FW-1:0] ONE_FX  = FW'(1) << FRAC_BITS;
	localparam logic [FW-1:0] HALF_FX = FW'(1) << (FRAC_BITS - 1);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_NORMALS = 3'd4;

	// saddle codes
	localparam logic [3:0] CODE_SADDLE_A = 4'h5;
	localparam logic [3:0] CODE_SADDLE_B = 4'hA;

	// cell edges
	localparam logic [1:0] EDGE_BOTTOM = 2'd0;   // p0-p1
	localparam logic [1:0] EDGE_RIGHT  = 2'd1;   // p1-p2
	localparam logic [1:0] EDGE_TOP    = 2'd2;   // p2-p3
	localparam logic [1:0] EDGE_LEFT   = 2'd3;   // p0-p3

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_FRAC = 5'b00100,
		S_DIV  = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [PIX_W-1:0] num;
		logic [PIX_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [FRAC_BITS-1:0] quot;
	} div_rsp_t;

	// number of segments per cell code
	function automatic logic [1:0] seg_count(input logic [3:0] code);
		case (code)
			4'h0, 4'hF: seg_count = 2'd0;
			4'h5, 4'hA: seg_count = 2'd2;
			default:    seg_count = 2'd1;
		endcase
	endfunction

	// edge of segment k, endpoint j: sel = {k, j}
	function automatic logic [1:0] seg_edge(input logic [3:0] code, input logic [1:0] sel);
		logic [7:0] row;
		begin
			case (code)
				4'h1, 4'hE: row = {2'd0, 2'd0, 2'd3, 2'd0};
				4'h2, 4'hD: row = {2'd0, 2'd0, 2'd1, 2'd0};
				4'h3, 4'hC: row = {2'd0, 2'd0, 2'd3, 2'd1};
				4'h4, 4'hB: row = {2'd0, 2'd0, 2'd2, 2'd1};
				4'h5:       row = {2'd3, 2'd2, 2'd1, 2'd0};
				4'h6, 4'h9: row = {2'd0, 2'd0, 2'd2, 2'd0};
				4'h7, 4'h8: row = {2'd0, 2'd0, 2'd3, 2'd2};
				4'hA:       row = {2'd2, 2'd1, 2'd3, 2'd0};
				default:    row = 8'd0;
			endcase
			seg_edge = row[{sel, 1'b0} +: 2];
		end
	endfunction

	// normal orientation of segment k
	function automatic logic orient(input logic [3:0] code, input logic k);
		case (code)
			4'h1, 4'h3, 4'h7, 4'h9, 4'hB, 4'hD: orient = !k;
			4'hA:    orient = k;
			default: orient = 1'b0;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> src/msq_pix_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msq_pix_if
// Pixel input channel: valid/ready handshake with one 8-bit pixel per beat.
// ----------------------------------------------------------------------------
interface msq_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface
`default_nettype wire

>>> src/msq_seg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msq_seg_if
// Segment output channel: valid/ready handshake with one segment per beat.
// ----------------------------------------------------------------------------
interface msq_seg_if;
	logic               valid;
	logic               ready;
	logic [17:0]        start_x;
	logic [17:0]        start_y;
	logic [17:0]        end_x;
	logic [17:0]        end_y;
	logic signed [10:0] normal_x;
	logic signed [10:0] normal_y;
	logic               last_segment;

	modport source (output valid, output start_x, output start_y, output end_x,
		output end_y, output normal_x, output normal_y, output last_segment,
		input ready);
	modport sink (input valid, input start_x, input start_y, input end_x,
		input end_y, input normal_x, input normal_y, input last_segment,
		output ready);
endinterface
`default_nettype wire

>>> src/marching_squares_segments.sv
`default_nettype none
// ----------------------------------------------------------------------------
// marching_squares_segments
// Marching squares isoline segment generator over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one at a time in raster order; the previous row sits in a
// single-port line buffer (registered read) that is read and rewritten at the
// pixel's column. Each pixel that completes a 2x2 cell yields zero to two
// segments on the output channel. A pixel that yields no segment passes
// through accept and the line buffer read only. Each segment adds an output
// step and a fraction step per endpoint; in smooth mode an endpoint on an edge
// with unequal corners whose crossing does not land on the far corner also
// runs the serial divider. The output register lets the next pixel enter
// while the last segment still waits to be taken. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module marching_squares_segments #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [msq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [msq_pkg::CFG_DATA_W-1:0]  cfg_data,
	msq_pix_if.sink                              in,
	msq_seg_if.source                            out
);

	localparam int AW  = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int PW  = ((AW > msq_pkg::ROW_W) ? AW : msq_pkg::ROW_W)
		+ msq_pkg::FRAC_BITS + 2;
	localparam int PXW = msq_pkg::PIX_W;
	localparam int FW  = msq_pkg::FW;

	// configuration registers
	logic [7:0]                thr_q;
	logic [10:0]               iw_q;
	logic [msq_pkg::HGT_W-1:0] ih_q;
	logic                      smooth_q;
	logic                      norm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 8'd128;
			iw_q     <= 11'd640;
			ih_q     <= 11'd480;
			smooth_q <= 1'b0;
			norm_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				msq_pkg::REG_THRESHOLD:    thr_q    <= cfg_data[7:0];
				msq_pkg::REG_IMAGE_WIDTH:  iw_q     <= cfg_data;
				msq_pkg::REG_IMAGE_HEIGHT: ih_q     <= cfg_data;
				msq_pkg::REG_SMOOTH_MODE:  smooth_q <= cfg_data[0];
				msq_pkg::REG_EMIT_NORMALS: norm_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective image size
	logic [WW-1:0]             w_eff;
	logic [msq_pkg::HGT_W-1:0] h_eff;

	always_comb begin
		if (iw_q < 11'd2)
			w_eff = WW'(2);
		else if (32'(iw_q) > MAX_WIDTH)
			w_eff = WW'(MAX_WIDTH);
		else
			w_eff = WW'(iw_q);
		if (ih_q < 11'd2)
			h_eff = 11'd2;
		else if (32'(ih_q) > msq_pkg::MAX_HEIGHT)
			h_eff = msq_pkg::HGT_W'(msq_pkg::MAX_HEIGHT);
		else
			h_eff = ih_q;
	end

	msq_pkg::state_t state_q;

	// raster counters
	logic [AW-1:0]             col_q;
	logic [msq_pkg::ROW_W-1:0] row_q;
	logic                      accept;
	logic                      in_row;
	logic                      cell_ok;
	logic [WW-1:0]             col_inc;
	logic [msq_pkg::HGT_W-1:0] row_inc;

	assign accept  = in.valid && in.ready;
	assign in_row  = WW'(col_q) < w_eff;
	assign cell_ok = in_row && (col_q != '0) && (row_q != '0)
		&& (msq_pkg::HGT_W'(row_q) < h_eff);
	assign col_inc = WW'(col_q) + 1'b1;
	assign row_inc = msq_pkg::HGT_W'(row_q) + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= w_eff) begin
				col_q <= '0;
				row_q <= (row_inc >= h_eff) ? '0 : row_inc[msq_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[AW-1:0];
			end
		end
	end

	// stage 1: accepted pixel and its position
	logic [PXW-1:0]            pix_s1;
	logic [AW-1:0]             col_s1;
	logic [msq_pkg::ROW_W-1:0] row_s1;
	logic                      in_row_s1;
	logic                      cell_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1    <= in.pixel;
			col_s1    <= col_q;
			row_s1    <= row_q;
			in_row_s1 <= in_row;
			cell_s1   <= cell_ok;
		end
	end

	// line buffer: read at accept, written back in the cycle after
	logic [PXW-1:0] row_mem [MAX_WIDTH];
	logic [PXW-1:0] rd_q;
	logic           mem_we;

	assign mem_we = (state_q == msq_pkg::S_READ) && in_row_s1;

	always_ff @(posedge clk) begin
		if (mem_we)
			row_mem[col_s1] <= pix_s1;
		if (accept && in_row)
			rd_q <= row_mem[col_q];
	end

	// cell classification
	logic [PXW-1:0] upper;
	logic [PXW-1:0] ul_q;
	logic [PXW-1:0] left_q;
	logic [3:0]     code_raw;
	logic [3:0]     code_fix;
	logic           flip_now;
	logic [9:0]     sum4;
	logic [9:0]     thr4;

	assign upper = in_row_s1 ? rd_q : '0;
	assign sum4  = 10'(ul_q) + 10'(upper) + 10'(pix_s1) + 10'(left_q);
	assign thr4  = {thr_q, 2'b00};
	assign code_raw = {left_q > thr_q, pix_s1 > thr_q, upper > thr_q, ul_q > thr_q};

	always_comb begin
		code_fix = code_raw;
		flip_now = 1'b0;
		if (code_raw == msq_pkg::CODE_SADDLE_A && sum4 <= thr4) begin
			code_fix = msq_pkg::CODE_SADDLE_B;
			flip_now = 1'b1;
		end else if (code_raw == msq_pkg::CODE_SADDLE_B && sum4 <= thr4) begin
			code_fix = msq_pkg::CODE_SADDLE_A;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ul_q   <= '0;
			left_q <= '0;
		end else if (state_q == msq_pkg::S_READ) begin
			ul_q   <= upper;
			left_q <= pix_s1;
		end
	end

	// cell registers for segment generation
	logic [PXW-1:0]            p_q [4];
	logic [3:0]                code_q;
	logic                      flip_q;
	logic [1:0]                cnt_q;
	logic [AW-1:0]             cx_q;
	logic [msq_pkg::ROW_W-1:0] cy_q;

	always_ff @(posedge clk) begin
		if (state_q == msq_pkg::S_READ) begin
			p_q[0] <= ul_q;
			p_q[1] <= upper;
			p_q[2] <= pix_s1;
			p_q[3] <= left_q;
			code_q <= code_fix;
			flip_q <= flip_now;
			cnt_q  <= msq_pkg::seg_count(code_fix);
			cx_q   <= col_s1 - 1'b1;
			cy_q   <= row_s1 - 1'b1;
		end
	end

	// endpoint fraction selection
	logic           seg_k_q;
	logic           end_sel_q;
	logic [1:0]     edge_sel;
	logic [PXW-1:0] pa;
	logic [PXW-1:0] pb;
	logic [PXW-1:0] num;
	logic [PXW-1:0] den;
	logic           need_div;
	logic [FW-1:0]  imm_frac;

	assign edge_sel = msq_pkg::seg_edge(code_q, {seg_k_q, end_sel_q});

	always_comb begin
		case (edge_sel)
			msq_pkg::EDGE_BOTTOM: begin pa = p_q[0]; pb = p_q[1]; end
			msq_pkg::EDGE_RIGHT:  begin pa = p_q[1]; pb = p_q[2]; end
			msq_pkg::EDGE_TOP:    begin pa = p_q[2]; pb = p_q[3]; end
			default:              begin pa = p_q[0]; pb = p_q[3]; end
		endcase
		num      = (thr_q > pa) ? thr_q - pa : pa - thr_q;
		den      = (pb > pa) ? pb - pa : pa - pb;
		need_div = smooth_q && (pa != pb) && (num < den);
		imm_frac = (!smooth_q || pa == pb) ? msq_pkg::HALF_FX : msq_pkg::ONE_FX;
	end

	// divider
	msq_pkg::div_req_t div_req;
	msq_pkg::div_rsp_t div_rsp;

	assign div_req.start = (state_q == msq_pkg::S_FRAC) && need_div;
	assign div_req.num   = num;
	assign div_req.den   = den;

	msq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// fraction registers of the current segment
	logic [FW-1:0] fs_q;
	logic [FW-1:0] fe_q;
	logic          frac_wr;
	logic [FW-1:0] frac_val;

	assign frac_wr  = ((state_q == msq_pkg::S_FRAC) && !need_div)
		|| ((state_q == msq_pkg::S_DIV) && div_rsp.done);
	assign frac_val = (state_q == msq_pkg::S_DIV) ? FW'(div_rsp.quot) : imm_frac;

	always_ff @(posedge clk) begin
		if (frac_wr) begin
			if (end_sel_q)
				fe_q <= frac_val;
			else
				fs_q <= frac_val;
		end
	end

	// crossing point of an edge, {x, y}, unflipped fixed point
	function automatic logic [2*PW-1:0] edge_pt(input logic [1:0] e,
		input logic [FW-1:0] f, input logic [AW-1:0] cx,
		input logic [msq_pkg::ROW_W-1:0] cy);
		logic [PW-1:0] bx;
		logic [PW-1:0] by;
		logic [PW-1:0] one;
		begin
			bx  = PW'(cx) << msq_pkg::FRAC_BITS;
			by  = PW'(cy) << msq_pkg::FRAC_BITS;
			one = PW'(msq_pkg::ONE_FX);
			case (e)
				msq_pkg::EDGE_BOTTOM: edge_pt = {bx + PW'(f), by};
				msq_pkg::EDGE_RIGHT:  edge_pt = {bx + one, by + PW'(f)};
				msq_pkg::EDGE_TOP:    edge_pt = {bx + one - PW'(f), by + one};
				default:              edge_pt = {bx, by + PW'(f)};
			endcase
		end
	endfunction

	// segment assembly
	logic [2*PW-1:0] sp;
	logic [2*PW-1:0] ep;
	logic [PW-1:0]   hf;
	logic [PW-1:0]   half;
	logic [PW-1:0]   sx;
	logic [PW-1:0]   sy;
	logic [PW-1:0]   ex;
	logic [PW-1:0]   ey;
	logic [PW-1:0]   dx;
	logic [PW-1:0]   dy;
	logic [PW-1:0]   nx;
	logic [PW-1:0]   ny;
	logic            pos;
	logic            last_now;
	logic            out_load;

	assign sp   = edge_pt(msq_pkg::seg_edge(code_q, {seg_k_q, 1'b0}), fs_q, cx_q, cy_q);
	assign ep   = edge_pt(msq_pkg::seg_edge(code_q, {seg_k_q, 1'b1}), fe_q, cx_q, cy_q);
	assign hf   = PW'(h_eff) << msq_pkg::FRAC_BITS;
	assign half = PW'(msq_pkg::HALF_FX);
	assign sx   = sp[2*PW-1:PW] + half;
	assign ex   = ep[2*PW-1:PW] + half;
	assign sy   = hf - sp[PW-1:0] - half;
	assign ey   = hf - ep[PW-1:0] - half;
	assign dx   = ex - sx;
	assign dy   = ey - sy;
	assign pos  = msq_pkg::orient(code_q, seg_k_q) ^ flip_q;
	assign nx   = pos ? -dx : dx;
	assign ny   = pos ? dy : -dy;
	assign last_now = seg_k_q || (cnt_q == 2'd1);
	assign out_load = (state_q == msq_pkg::S_EMIT) && (!out.valid || out.ready);

	// output register
	logic ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (out_load)
			ov_q <= 1'b1;
		else if (out.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out.start_x      <= sx[msq_pkg::COORD_W-1:0];
			out.start_y      <= sy[msq_pkg::COORD_W-1:0];
			out.end_x        <= ex[msq_pkg::COORD_W-1:0];
			out.end_y        <= ey[msq_pkg::COORD_W-1:0];
			out.normal_x     <= norm_q ? nx[msq_pkg::NORM_W-1:0] : '0;
			out.normal_y     <= norm_q ? ny[msq_pkg::NORM_W-1:0] : '0;
			out.last_segment <= last_now;
		end
	end

	assign out.valid = ov_q;
	assign in.ready  = (state_q == msq_pkg::S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= msq_pkg::S_IDLE;
			seg_k_q   <= 1'b0;
			end_sel_q <= 1'b0;
		end else begin
			case (state_q)
				msq_pkg::S_IDLE: begin
					if (accept)
						state_q <= msq_pkg::S_READ;
				end
				msq_pkg::S_READ: begin
					seg_k_q   <= 1'b0;
					end_sel_q <= 1'b0;
					if (cell_s1 && msq_pkg::seg_count(code_fix) != 2'd0)
						state_q <= msq_pkg::S_FRAC;
					else
						state_q <= msq_pkg::S_IDLE;
				end
				msq_pkg::S_FRAC, msq_pkg::S_DIV: begin
					if (state_q == msq_pkg::S_FRAC && need_div) begin
						state_q <= msq_pkg::S_DIV;
					end else if (frac_wr) begin
						end_sel_q <= !end_sel_q;
						state_q   <= end_sel_q ? msq_pkg::S_EMIT : msq_pkg::S_FRAC;
					end
				end
				msq_pkg::S_EMIT: begin
					if (out_load) begin
						if (last_now) begin
							state_q <= msq_pkg::S_IDLE;
						end else begin
							seg_k_q <= 1'b1;
							state_q <= msq_pkg::S_FRAC;
						end
					end
				end
				default: state_q <= msq_pkg::S_IDLE;
			endcase
		end
	end

	// checks
	a_div_smooth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == msq_pkg::S_DIV |-> smooth_q)
		else $error("divider running outside smooth mode");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == msq_pkg::S_DIV)
		else $error("divider result outside divide state");

	a_second_seg: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !last_now |=> state_q == msq_pkg::S_FRAC && seg_k_q)
		else $error("second segment not started");

	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == msq_pkg::S_READ)
		else $error("accepted beat not followed by line buffer read");

endmodule
`default_nettype wire

>>> src/msq_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msq_div
// Restoring divider for the edge crossing fraction:
// quot = floor((num * 2^(F+1) + den) / (2 * den)), valid for num < den.
// One quotient bit per cycle; done pulses after the last bit.
// ----------------------------------------------------------------------------
module msq_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msq_pkg::div_req_t req,
	output msq_pkg::div_rsp_t      rsp
);

	logic                         busy_q;
	logic                         done_q;
	logic [msq_pkg::DIV_CW-1:0]   cnt_q;
	logic [msq_pkg::DIV_NW-1:0]   rem_q;
	logic [msq_pkg::DIV_DW-1:0]   dsr_q;
	logic [msq_pkg::FRAC_BITS-1:0] quot_q;
	logic [msq_pkg::DIV_NW-1:0]   trial;
	logic                         fits;

	// shifted divisor for the current bit
	assign trial = msq_pkg::DIV_NW'(dsr_q) << cnt_q;
	assign fits  = rem_q >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= msq_pkg::DIV_CW'(msq_pkg::FRAC_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {req.num, {(msq_pkg::FRAC_BITS + 1){1'b0}}}
				+ msq_pkg::DIV_NW'(req.den);
			dsr_q  <= {req.den, 1'b0};
			quot_q <= '0;
		end else if (busy_q && fits) begin
			rem_q         <= rem_q - trial;
			quot_q[cnt_q] <= 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire

>>> dv/tb_marching_squares_segments.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_marching_squares_segments
// Self-checking testbench for the marching squares segment generator.
// ----------------------------------------------------------------------------
// A directed table walks the saddle cells, the shrunk-width wrap and a
// zero threshold. Random image phases follow, each under its own
// settings. Every accepted pixel is run through a cell predictor that queues
// the segments it should cause. Each output beat is checked field by field
// against the oldest queued segment. Both channels stall in random bursts
// except near the end of the run.
// ----------------------------------------------------------------------------
module tb_marching_squares_segments;

	localparam int     SETTLE_CYCLES = 60;
	localparam longint CYCLE_LIMIT   = 3000000;
	localparam int     RANDOM_ITEMS  = 350;

	typedef struct {
		logic [msq_pkg::COORD_W-1:0]       sx, sy, ex, ey;
		logic signed [msq_pkg::NORM_W-1:0] nx, ny;
		logic                              last;
	} segment_t;

	typedef enum logic {ROW_REG, ROW_PIX} row_kind_t;
	typedef struct {
		row_kind_t                     kind;
		logic [msq_pkg::CFG_IDX_W-1:0] idx;
		int                            val;
		int                            nseg;   // -1: left to the predictor
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [msq_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [msq_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	msq_pix_if pix_ch ();
	msq_seg_if seg_ch ();

	marching_squares_segments dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in(pix_ch.sink), .out(seg_ch.source)
	);

	always #5 clk = ~clk;

	// cell tables: segment count, edge pairs and normal orientation per code
	localparam int NSEG [16] = '{0,1,1,1,1,2,1,1,1,1,2,1,1,1,1,0};
	localparam int PAIRS [16][4] = '{
		'{0,0,0,0}, '{0,3,0,0}, '{0,1,0,0}, '{1,3,0,0},
		'{1,2,0,0}, '{0,1,2,3}, '{0,2,0,0}, '{2,3,0,0},
		'{2,3,0,0}, '{0,2,0,0}, '{0,3,1,2}, '{1,2,0,0},
		'{1,3,0,0}, '{0,1,0,0}, '{0,3,0,0}, '{0,0,0,0}};
	localparam int FLIPSIGN [16][2] = '{
		'{0,0}, '{1,0}, '{0,0}, '{1,0}, '{0,0}, '{0,0}, '{0,0}, '{1,0},
		'{0,0}, '{1,0}, '{0,1}, '{1,0}, '{0,0}, '{1,0}, '{0,0}, '{0,0}};

	// predictor state and register copies
	logic [msq_pkg::PIX_W-1:0] line_buf [1024];
	logic [msq_pkg::PIX_W-1:0] prev_pix, prev_upper;
	int unsigned col_cnt, row_cnt;
	int unsigned thr_reg, width_reg, height_reg, smooth_reg, normals_reg;

	segment_t seg_q [$];
	int       err_cnt = 0;
	longint   cycles = 0;
	bit       calm = 1'b0;

	function automatic int unsigned eff_width(int unsigned w);
		return w < 2 ? 2 : (w > 1024 ? 1024 : w);
	endfunction

	function automatic int unsigned eff_height(int unsigned h);
		return h < 2 ? 2 : (h > msq_pkg::MAX_HEIGHT ? msq_pkg::MAX_HEIGHT : h);
	endfunction

	// crossing fraction from corner a toward corner b, 8 fraction bits
	function automatic longint crossing_frac(int a, int b);
		longint num, den, f;
		if (smooth_reg == 0 || a == b) return 128;
		num = (thr_reg > a) ? thr_reg - a : a - thr_reg;
		den = (b > a) ? b - a : a - b;
		f = (num * 512 + den) / (2 * den);
		return f > 256 ? 256 : f;
	endfunction

	task automatic crossing_point(input int e, input longint cx, input longint cy,
			input int p [4], output longint px, output longint py);
		longint bx, by;
		bx = cx * 256;
		by = cy * 256;
		case (e[1:0])
			msq_pkg::EDGE_BOTTOM: begin
				px = bx + crossing_frac(p[0], p[1]); py = by;
			end
			msq_pkg::EDGE_RIGHT: begin
				px = bx + 256; py = by + crossing_frac(p[1], p[2]);
			end
			msq_pkg::EDGE_TOP: begin
				px = bx + 256 - crossing_frac(p[2], p[3]); py = by + 256;
			end
			default: begin px = bx; py = by + crossing_frac(p[0], p[3]); end
		endcase
	endtask

	// advance the predictor by one accepted pixel, queue its segments
	task automatic predict_cell(input logic [msq_pkg::PIX_W-1:0] pix, output int nseg);
		int unsigned w, h, c, r, code, sum;
		int p [4];
		logic [msq_pkg::PIX_W-1:0] upper;
		bit flipped, pos;
		longint sx, sy, ex, ey, hf, dx, dy, nxv, nyv;
		segment_t s;
		w = eff_width(width_reg);
		h = eff_height(height_reg);
		c = col_cnt;
		r = row_cnt;
		upper = '0;
		nseg = 0;
		if (c < w) begin
			upper = line_buf[c];
			if (c >= 1 && r >= 1 && r < h) begin
				p[0] = prev_upper; p[1] = upper; p[2] = pix; p[3] = prev_pix;
				code = 0;
				for (int k = 0; k < 4; k++)
					if (p[k] > thr_reg) code |= 1 << k;
				sum = p[0] + p[1] + p[2] + p[3];
				flipped = 1'b0;
				if (code == msq_pkg::CODE_SADDLE_A && sum <= thr_reg * 4) begin
					code = msq_pkg::CODE_SADDLE_B;
					flipped = 1'b1;
				end else if (code == msq_pkg::CODE_SADDLE_B && sum <= thr_reg * 4) begin
					code = msq_pkg::CODE_SADDLE_A;
				end
				hf = longint'(h) * 256;
				for (int k = 0; k < NSEG[code]; k++) begin
					crossing_point(PAIRS[code][2*k], c - 1, r - 1, p, sx, sy);
					crossing_point(PAIRS[code][2*k+1], c - 1, r - 1, p, ex, ey);
					sx += 128; ex += 128;
					sy = hf - sy - 128;
					ey = hf - ey - 128;
					s.sx = sx[msq_pkg::COORD_W-1:0]; s.sy = sy[msq_pkg::COORD_W-1:0];
					s.ex = ex[msq_pkg::COORD_W-1:0]; s.ey = ey[msq_pkg::COORD_W-1:0];
					s.nx = '0; s.ny = '0;
					if (normals_reg != 0) begin
						pos = FLIPSIGN[code][k] != 0;
						if (flipped) pos = !pos;
						dx = ex - sx;
						dy = ey - sy;
						nxv = pos ? -dx : dx;
						nyv = pos ? dy : -dy;
						s.nx = nxv[msq_pkg::NORM_W-1:0];
						s.ny = nyv[msq_pkg::NORM_W-1:0];
					end
					s.last = (k == NSEG[code] - 1);
					seg_q = {seg_q, s};
				end
				nseg = NSEG[code];
			end
			line_buf[c] = pix;
		end
		prev_upper = upper;
		prev_pix = pix;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_cnt = c;
		row_cnt = r;
	endtask

	// one pixel beat, with an optional gap in front of it
	task automatic send_pixel(input logic [msq_pkg::PIX_W-1:0] pix, output int nseg);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			pix_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= pix;
		do @(posedge clk); while (!pix_ch.ready);
		predict_cell(pix, nseg);
	endtask

	// drop valid and wait until the block has nothing left in flight
	task automatic drain();
		@(negedge clk);
		pix_ch.valid <= 1'b0;
		wait (seg_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [msq_pkg::PIX_W-1:0] pick_pixel();
		int v;
		case ($urandom_range(0, 3))
			0: v = $urandom_range(0, 1) ? 255 : 0;
			1: begin
				v = int'(thr_reg) + $urandom_range(0, 6) - 3;
				v = v < 0 ? 0 : (v > 255 ? 255 : v);
			end
			default: v = $urandom_range(0, 255);
		endcase
		return v[msq_pkg::PIX_W-1:0];
	endfunction

	// register write at idle; a wider row first finishes the image so the
	// line buffer is refilled before it is read
	task automatic write_reg(input logic [msq_pkg::CFG_IDX_W-1:0] idx, input int val);
		int n;
		if (idx == msq_pkg::REG_IMAGE_WIDTH &&
				eff_width(val & 'h7FF) > eff_width(width_reg))
			while (row_cnt != 0) send_pixel(pick_pixel(), n);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[msq_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			msq_pkg::REG_THRESHOLD:    thr_reg = val & 'hFF;
			msq_pkg::REG_IMAGE_WIDTH:  width_reg = val & 'h7FF;
			msq_pkg::REG_IMAGE_HEIGHT: height_reg = val & 'h7FF;
			msq_pkg::REG_SMOOTH_MODE:  smooth_reg = val & 1;
			msq_pkg::REG_EMIT_NORMALS: normals_reg = val & 1;
			default: ;
		endcase
	endtask

	// receiver: random stall bursts, always ready once calm
	int stall_left = 0;
	always @(negedge clk) begin
		if (calm) begin
			seg_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			seg_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left <= $urandom_range(0, 10);
			seg_ch.ready <= 1'b0;
		end else begin
			seg_ch.ready <= 1'b1;
		end
	end

	// output beat check against the oldest queued segment
	always @(posedge clk) begin
		segment_t s;
		if (arst_n && seg_ch.valid && seg_ch.ready) begin
			if (seg_q.size() == 0) begin
				$error("unexpected segment beat");
				err_cnt++;
			end else begin
				s = seg_q.pop_front();
				if (seg_ch.start_x !== s.sx) begin
					$error("start_x expected %0d got %0d", s.sx, seg_ch.start_x);
					err_cnt++;
				end
				if (seg_ch.start_y !== s.sy) begin
					$error("start_y expected %0d got %0d", s.sy, seg_ch.start_y);
					err_cnt++;
				end
				if (seg_ch.end_x !== s.ex) begin
					$error("end_x expected %0d got %0d", s.ex, seg_ch.end_x);
					err_cnt++;
				end
				if (seg_ch.end_y !== s.ey) begin
					$error("end_y expected %0d got %0d", s.ey, seg_ch.end_y);
					err_cnt++;
				end
				if (seg_ch.normal_x !== s.nx) begin
					$error("normal_x expected %0d got %0d", s.nx, seg_ch.normal_x);
					err_cnt++;
				end
				if (seg_ch.normal_y !== s.ny) begin
					$error("normal_y expected %0d got %0d", s.ny, seg_ch.normal_y);
					err_cnt++;
				end
				if (seg_ch.last_segment !== s.last) begin
					$error("last_segment expected %0b got %0b", s.last,
						seg_ch.last_segment);
					err_cnt++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// directed table: saddles, shrunk width, zero threshold
	plan_row_t plan [21] = '{
		'{ROW_REG, msq_pkg::REG_IMAGE_WIDTH, 4, -1},
		'{ROW_REG, msq_pkg::REG_IMAGE_HEIGHT, 3, -1},
		'{ROW_PIX, '0, 0, 0},
		'{ROW_PIX, '0, 255, 0},
		'{ROW_PIX, '0, 0, 0},
		'{ROW_REG, msq_pkg::REG_IMAGE_WIDTH, 2, -1},    // column now past the row end
		'{ROW_PIX, '0, 77, 0},
		'{ROW_PIX, '0, 255, 0},
		'{ROW_PIX, '0, 0, 2},                   // saddle resolved to the other code
		'{ROW_PIX, '0, 255, 0},
		'{ROW_PIX, '0, 255, -1},
		'{ROW_REG, msq_pkg::REG_SMOOTH_MODE, 1, -1},
		'{ROW_REG, msq_pkg::REG_EMIT_NORMALS, 1, -1},
		'{ROW_REG, msq_pkg::REG_THRESHOLD, 0, -1},
		'{ROW_PIX, '0, 0, 0},
		'{ROW_PIX, '0, 255, 0},
		'{ROW_PIX, '0, 255, 0},
		'{ROW_PIX, '0, 0, 2},
		'{ROW_REG, msq_pkg::REG_THRESHOLD, 100, -1},
		'{ROW_PIX, '0, 0, 0},
		'{ROW_PIX, '0, 140, 2}                  // low-average saddle, flipped
	};

	initial begin
		int n, sent, budget;
		int unsigned w, h;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		seg_ch.ready = 1'b0;
		thr_reg = 128; width_reg = 640; height_reg = 480;
		smooth_reg = 0; normals_reg = 0;
		prev_pix = '0; prev_upper = '0;
		col_cnt = 0; row_cnt = 0;
		foreach (line_buf[i]) line_buf[i] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				send_pixel(plan[i].val[msq_pkg::PIX_W-1:0], n);
				if (plan[i].nseg >= 0 && n != plan[i].nseg) begin
					$error("segment count expected %0d got %0d", plan[i].nseg, n);
					err_cnt++;
				end
			end
		end

		// largest sizes: out-of-range width, then out-of-range height
		write_reg(msq_pkg::REG_IMAGE_HEIGHT, 2);
		write_reg(msq_pkg::REG_IMAGE_WIDTH, 2000);
		for (int i = 0; i < 1030; i++) send_pixel(pick_pixel(), n);
		write_reg(msq_pkg::REG_IMAGE_WIDTH, 1);
		write_reg(msq_pkg::REG_IMAGE_HEIGHT, 2047);
		for (int i = 0; i < 40; i++) send_pixel(pick_pixel(), n);
		write_reg(msq_pkg::REG_IMAGE_HEIGHT, 2);

		// random image phases
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			write_reg(msq_pkg::REG_THRESHOLD, $urandom_range(0, 3) == 0 ?
				($urandom_range(0, 1) ? 255 : 0) : $urandom_range(0, 255));
			write_reg(msq_pkg::REG_IMAGE_WIDTH, $urandom_range(0, 7) == 0 ?
				$urandom_range(0, 1) : $urandom_range(2, 16));
			write_reg(msq_pkg::REG_IMAGE_HEIGHT, $urandom_range(0, 7) == 0 ?
				$urandom_range(0, 1) : $urandom_range(2, 10));
			write_reg(msq_pkg::REG_SMOOTH_MODE, $urandom_range(0, 1));
			write_reg(msq_pkg::REG_EMIT_NORMALS, $urandom_range(0, 1));
			w = eff_width(width_reg);
			h = eff_height(height_reg);
			budget = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
			for (int i = 0; i < budget; i++) begin
				send_pixel(pick_pixel(), n);
				sent++;
				if (sent == RANDOM_ITEMS / 2) drain();
				if (sent > RANDOM_ITEMS * 7 / 8) calm = 1'b1;
			end
		end

		@(negedge clk);
		pix_ch.valid <= 1'b0;
		wait (seg_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

>>> marching_squares_segments.f
src/msq_pkg.sv
src/msq_pix_if.sv
src/msq_seg_if.sv
src/msq_div.sv
src/marching_squares_segments.sv
dv/tb_marching_squares_segments.sv
